FILE: hw/rtl/fpg_pkg.sv
package fpg_pkg;

  typedef enum logic [2:0] {
    ActSample   = 3'd0,
    ActFrameBeg = 3'd1,
    ActFrameEnd = 3'd2,
    ActBgTry    = 3'd3,
    ActBgEnd    = 3'd4,
    ActQuery    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    GradeLow    = 2'd0,
    GradeNormal = 2'd1,
    GradeHigh   = 2'd2,
    GradeOver   = 2'd3
  } grade_e;

  typedef enum logic [1:0] {
    CfgAvail   = 2'd0,
    CfgThermal = 2'd1,
    CfgMobile  = 2'd2,
    CfgLarge   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ClassBg      = 2'd0,
    ClassInter   = 2'd1,
    ClassFrame   = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    ThermNominal  = 2'd0,
    ThermFair     = 2'd1,
    ThermSerious  = 2'd2,
    ThermCritical = 2'd3
  } therm_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ScaledW  = 36;  // 32-bit value times at most 14

  localparam logic [31:0] LargeItemsReset = 32'(96 * 1024);
  localparam logic [3:0]  BoostOverload   = 4'd12;
  localparam logic [3:0]  BoostHigh       = 4'd6;
  localparam logic [ScaledW-1:0] ScaleSample = ScaledW'(10);
  localparam logic [ScaledW-1:0] ScaleLow    = ScaledW'(8);
  localparam logic [ScaledW-1:0] ScaleNormal = ScaledW'(11);
  localparam logic [ScaledW-1:0] ScaleHigh   = ScaledW'(14);
  localparam logic [1:0]  HelpersMax      = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] elapsed_ns;
    logic [31:0] target_ns;
    logic [1:0]  job_class;
    logic [31:0] job_items;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] helper_count;
    logic       granted;
    logic [1:0] frame_level;
    logic       boost_on;
    logic [7:0] frame_jobs;
    logic       background_busy;
  } out_beat_t;

endpackage

FILE: hw/rtl/fpg_in_if.sv
interface fpg_in_if
  import fpg_pkg::*;
();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/fpg_out_if.sv
interface fpg_out_if
  import fpg_pkg::*;
();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/frame_pressure_helper_governor_unit.sv
// Channel  Dir  Modport  Beat payload
// -------  ---  -------  ----------------------------------------------------
// in_i     in   sink     action, elapsed_ns, target_ns, job_class, job_items
// out_o    out  source   helper_count, granted, frame_level, boost_on,
//                        frame_jobs, background_busy
// cfg      in   -        cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// One beat per cycle sustained while out_o takes its beats; the path is an input
// register that also holds the scaled interval products, then state update into
// the result register, so the next beat always sees the updated governor state.
// Async active-low reset clears both valid flags and the governor state and loads
// the config defaults. A stall on out_o holds both stages; in_i.ready drops only
// when both stages are full and out_o is not taking its beat.
module frame_pressure_helper_governor_unit
  import fpg_pkg::*;
#(
  parameter int unsigned MAX_FRAME_JOBS = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fpg_in_if.sink              in_i,
  fpg_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // frame job count saturates at the parameter, never past 8 bits
  localparam int unsigned JobCapInt = (MAX_FRAME_JOBS < 255) ? MAX_FRAME_JOBS : 255;
  localparam logic [7:0]  JobCap    = 8'(JobCapInt);

  typedef struct packed {
    logic [2:0]         action;
    logic               sample_zero;
    logic [ScaledW-1:0] e10;
    logic [ScaledW-1:0] t8;
    logic [ScaledW-1:0] t11;
    logic [ScaledW-1:0] t14;
    logic [1:0]         job_class;
    logic [31:0]        job_items;
  } s1_t;

  // config registers
  logic [1:0]  avail_q;
  logic [1:0]  thermal_q;
  logic        mobile_q;
  logic [31:0] large_q;

  // governor state
  logic [1:0] grade_q, grade_d;
  logic [3:0] boost_q, boost_d;
  logic [7:0] jobs_q, jobs_d;
  logic       token_q, token_d;

  // pipeline
  logic      s1_valid_q;
  s1_t       s1_q;
  logic      out_valid_q;
  out_beat_t out_q, out_d;

  logic s1_adv, in_take;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q   <= HelpersMax;
      thermal_q <= ThermNominal;
      mobile_q  <= 1'b0;
      large_q   <= LargeItemsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAvail:   avail_q   <= cfg_data_i[1:0];
        CfgThermal: thermal_q <= cfg_data_i[1:0];
        CfgMobile:  mobile_q  <= cfg_data_i[0];
        CfgLarge:   large_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: capture and scale the interval sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.action      <= in_i.data.action;
      s1_q.sample_zero <= (in_i.data.elapsed_ns == '0) || (in_i.data.target_ns == '0);
      s1_q.e10         <= ScaledW'(in_i.data.elapsed_ns) * ScaleSample;
      s1_q.t8          <= ScaledW'(in_i.data.target_ns) * ScaleLow;
      s1_q.t11         <= ScaledW'(in_i.data.target_ns) * ScaleNormal;
      s1_q.t14         <= ScaledW'(in_i.data.target_ns) * ScaleHigh;
      s1_q.job_class   <= in_i.data.job_class;
      s1_q.job_items   <= in_i.data.job_items;
    end
  end

  // stage 2: grade, state update, helper policy
  logic [1:0] avail_sat;
  logic       bg_ok;
  logic       boost_act;
  logic [1:0] grade_new;
  logic [1:0] helpers;
  logic       grant;

  assign avail_sat = (avail_q == 2'd3) ? HelpersMax : avail_q;
  assign bg_ok     = (jobs_q == '0) && (thermal_q < ThermSerious) && (grade_q < GradeHigh);
  assign boost_act = (boost_q != '0);

  always_comb begin
    if (s1_q.e10 <= s1_q.t8) begin
      grade_new = GradeLow;
    end else if (s1_q.e10 <= s1_q.t11) begin
      grade_new = GradeNormal;
    end else if (s1_q.e10 <= s1_q.t14) begin
      grade_new = GradeHigh;
    end else begin
      grade_new = GradeOver;
    end
  end

  // policy checked in priority order; unused class three acts as interactive
  always_comb begin
    if (avail_sat == '0 || thermal_q == ThermCritical) begin
      helpers = '0;
    end else if (s1_q.job_class == ClassBg) begin
      helpers = {1'b0, bg_ok};
    end else if (thermal_q == ThermSerious) begin
      helpers = {1'b0, !mobile_q};
    end else if (mobile_q) begin
      if (s1_q.job_class == ClassFrame) begin
        if (grade_q == GradeOver) begin
          helpers = avail_sat;
        end else begin
          helpers = {1'b0, (grade_q == GradeHigh) || boost_act};
        end
      end else begin
        helpers = {1'b0, boost_act};
      end
    end else if (s1_q.job_class == ClassFrame && s1_q.job_items >= large_q) begin
      helpers = avail_sat;
    end else begin
      helpers = 2'd1;
    end
  end

  always_comb begin
    grade_d = grade_q;
    boost_d = boost_q;
    jobs_d  = jobs_q;
    token_d = token_q;
    grant   = 1'b0;
    case (s1_q.action)
      ActSample: begin
        if (!s1_q.sample_zero) begin
          grade_d = grade_new;
          if (grade_new == GradeOver) begin
            boost_d = BoostOverload;
          end else if (grade_new == GradeHigh) begin
            if (boost_q < BoostHigh) boost_d = BoostHigh;
          end else if (boost_act) begin
            boost_d = boost_q - 4'd1;
          end
        end
      end
      ActFrameBeg: begin
        if (jobs_q < JobCap) jobs_d = jobs_q + 8'd1;
      end
      ActFrameEnd: begin
        if (jobs_q != '0) jobs_d = jobs_q - 8'd1;
      end
      ActBgTry: begin
        if (bg_ok && !token_q) begin
          token_d = 1'b1;
          grant   = 1'b1;
        end
      end
      ActBgEnd: begin
        token_d = 1'b0;
      end
      default: ;
    endcase

    out_d.helper_count    = (s1_q.action == ActQuery) ? helpers : '0;
    out_d.granted         = grant;
    out_d.frame_level     = grade_d;
    out_d.boost_on        = (boost_d != '0);
    out_d.frame_jobs      = jobs_d;
    out_d.background_busy = token_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grade_q     <= GradeNormal;
      boost_q     <= '0;
      jobs_q      <= '0;
      token_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        grade_q <= grade_d;
        boost_q <= boost_d;
        jobs_q  <= jobs_d;
        token_q <= token_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= out_d;
  end

  // checks
  a_jobs_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jobs_q <= JobCap)
    else $error("frame job count above cap");

  a_boost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boost_q <= BoostOverload)
    else $error("boost hold out of range");

  a_grant_holds_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.granted |-> out_q.background_busy)
    else $error("grant without token held");

  a_helpers_query_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_q.action != ActQuery) |=> out_q.helper_count == '0)
    else $error("helper count on a non-query beat");

  a_over_sets_boost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (grade_d == GradeOver) && (grade_q != GradeOver) |=> boost_q != '0)
    else $error("overload entered without boost");

endmodule
